// ===== rtl/core/cdfe_pkg.sv =====
// Shared types, constants and a helper function for the countdown display frame encoder.
package cdfe_pkg;

	localparam int LANES = 3;
	localparam int FRAME_LEN = 5;

	localparam logic [7:0] FRAME_HEAD = 8'hFE;
	localparam logic [7:0] MARK_BIT = 8'h20;
	localparam logic [7:0] CHECK_MASK = 8'h7F;
	localparam logic [7:0] MIN_START = 8'd254;
	localparam logic [7:0] BLANK_COUNT = 8'd99;

	// Light colors as carried by the lanes and the held state.
	localparam logic [1:0] COL_RED = 2'd0;
	localparam logic [1:0] COL_YELLOW = 2'd1;
	localparam logic [1:0] COL_GREEN = 2'd2;
	localparam logic [1:0] COL_IGNORED = 2'd3;

	// Frame kinds.
	localparam logic KIND_COUNTDOWN = 1'b0;
	localparam logic KIND_BLANK = 1'b1;

	localparam logic [1:0] DIR_NORTH = 2'd0;

	// What one lane contributes after qualification.
	typedef struct packed {
		logic       hit;
		logic [1:0] color;
		logic [7:0] secs;
	} lane_t;

	// Color and count remembered between countdown frames.
	typedef struct packed {
		logic [1:0] color;
		logic [7:0] count;
	} held_t;

	// Frame bytes after the fixed head.
	typedef struct packed {
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} frame_t;

	localparam logic [2:0] IDX_LAST = 3'(FRAME_LEN - 1);

	// Display color code; the ignored slot stands for color none.
	function automatic logic [1:0] color_code(input logic [1:0] col);
		logic [1:0] code;
		unique case (col)
			COL_RED: code = 2'd3;
			COL_YELLOW: code = 2'd2;
			COL_GREEN: code = 2'd1;
			default: code = 2'd0;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/core/countdown_display_frame_encoder.sv =====
// Top level of the countdown display frame encoder.
// Flow: an accepted word is registered in the lane register; when the serializer is free, the frame
// is loaded and its first output word appears in the cycle after; the five words follow one per cycle
// while out_ready is high. The next input is taken while the current frame is still being sent.
// Reset: arst_n clears the pipeline valid flags, the word counter and the held color (red) and count (0).
module countdown_display_frame_encoder import cdfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [1:0] direction,
	input  logic       left_active,
	input  logic [1:0] left_color,
	input  logic [7:0] left_seconds,
	input  logic       straight_active,
	input  logic [1:0] straight_color,
	input  logic [7:0] straight_seconds,
	input  logic       right_active,
	input  logic [1:0] right_color,
	input  logic [7:0] right_seconds,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       frame_last
);

	lane_t [LANES-1:0] lanes;
	lane_t [LANES-1:0] lanes_s1;
	logic              valid_s1;
	logic              kind_s1;
	logic [1:0]        dir_s1;
	held_t             held_q;
	held_t             held_next;
	frame_t            frame;
	logic              ser_free;
	logic              load;
	logic              in_take;

	// Lane qualifiers, one per lane.
	cdfe_lane u_lane_left (
		.active  (left_active),
		.color   (left_color),
		.seconds (left_seconds),
		.lane    (lanes[0])
	);

	cdfe_lane u_lane_straight (
		.active  (straight_active),
		.color   (straight_color),
		.seconds (straight_seconds),
		.lane    (lanes[1])
	);

	cdfe_lane u_lane_right (
		.active  (right_active),
		.color   (right_color),
		.seconds (right_seconds),
		.lane    (lanes[2])
	);

	// Handshake for the lane register.
	assign load = valid_s1 && ser_free;
	assign in_ready = !valid_s1 || load;
	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			lanes_s1 <= lanes;
			kind_s1 <= kind;
			dir_s1 <= direction;
		end
	end

	// Merge of the lane findings into the frame.
	cdfe_merge u_merge (
		.kind      (kind_s1),
		.direction (dir_s1),
		.lanes     (lanes_s1),
		.held      (held_q),
		.held_next (held_next),
		.frame     (frame)
	);

	// Held color and count advance as each frame enters the serializer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q.color <= COL_RED;
			held_q.count <= 8'd0;
		end else if (load) begin
			held_q <= held_next;
		end
	end

	cdfe_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.frame      (frame),
		.free       (ser_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule

// ===== rtl/core/cdfe_lane.sv =====
// One lane qualifier: decides whether a lane takes part and saturates its time.
module cdfe_lane import cdfe_pkg::*; (
	input  logic       active,
	input  logic [1:0] color,
	input  logic [7:0] seconds,
	output lane_t      lane
);

	// A lane counts only when active and its color is not the ignored code.
	always_comb begin
		lane.hit = active && (color != COL_IGNORED);
		lane.color = color;
		lane.secs = (seconds > MIN_START) ? MIN_START : seconds;
	end

endmodule

// ===== rtl/core/cdfe_merge.sv =====
// Merge stage: color priority, per-color minimum, held state update and frame bytes.
module cdfe_merge import cdfe_pkg::*; (
	input  logic                  kind,
	input  logic [1:0]            direction,
	input  lane_t [LANES-1:0]     lanes,
	input  held_t                 held,
	output held_t                 held_next,
	output frame_t                frame
);

	logic [2:0]      seen;
	logic [2:0][7:0] minv;
	held_t           base;
	logic [1:0]      out_color;
	logic [7:0]      count;
	logic [1:0]      hund;
	logic [6:0]      rem;
	logic [14:0]     prod;
	logic [3:0]      tens;
	logic [3:0]      ones;

	// Per-color presence and minimum over the three lanes.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			seen[c] = 1'b0;
			minv[c] = MIN_START;
			for (int l = 0; l < LANES; l++) begin
				if (lanes[l].hit && (lanes[l].color == 2'(c))) begin
					seen[c] = 1'b1;
					if (lanes[l].secs < minv[c]) begin
						minv[c] = lanes[l].secs;
					end
				end
			end
		end
	end

	// Countdown: highest-priority color seen, else held or north-cleared; blank: held.
	always_comb begin
		base = held;
		if (direction == DIR_NORTH) begin
			base.color = COL_RED;
			base.count = 8'd0;
		end
		held_next = held;
		if (kind == KIND_COUNTDOWN) begin
			priority if (seen[COL_GREEN]) begin
				held_next.color = COL_GREEN;
				held_next.count = minv[COL_GREEN];
			end else if (seen[COL_YELLOW]) begin
				held_next.color = COL_YELLOW;
				held_next.count = minv[COL_YELLOW];
			end else if (seen[COL_RED]) begin
				held_next.color = COL_RED;
				held_next.count = minv[COL_RED];
			end else begin
				held_next = base;
			end
		end
	end

	// Blank frames show color none and a fixed count.
	always_comb begin
		if (kind == KIND_BLANK) begin
			out_color = COL_IGNORED;
			count = BLANK_COUNT;
		end else begin
			out_color = held_next.color;
			count = held_next.count;
		end
	end

	// Decimal digits: hundreds by compare, tens by reciprocal multiply.
	always_comb begin
		priority if (count >= 8'd200) begin
			hund = 2'd2;
			rem = 7'(count - 8'd200);
		end else if (count >= 8'd100) begin
			hund = 2'd1;
			rem = 7'(count - 8'd100);
		end else begin
			hund = 2'd0;
			rem = count[6:0];
		end
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = 4'(rem - 7'(tens) * 7'd10);
	end

	// Frame bytes after the head.
	always_comb begin
		frame.b1 = {6'd0, color_code(out_color)} | {4'd0, direction, 2'd0} | MARK_BIT;
		frame.b2 = {6'd0, hund};
		frame.b3 = {tens, ones};
		frame.b4 = CHECK_MASK & (frame.b1 ^ frame.b2 ^ frame.b3);
	end

endmodule

// ===== rtl/core/cdfe_ser.sv =====
// Serializer: holds one frame, sends five words one per cycle if out_ready.
module cdfe_ser import cdfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  frame_t     frame,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       frame_last
);

	frame_t     frame_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       take;

	assign take = busy_q && out_ready;
	assign free = !busy_q || (take && (idx_q == IDX_LAST));

	// Word counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (take) begin
			if (idx_q == IDX_LAST) begin
				busy_q <= 1'b0;
				idx_q <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Frame bytes are captured when a new frame is loaded.
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

	// Word selection.
	always_comb begin
		unique case (idx_q)
			3'd0: frame_byte = FRAME_HEAD;
			3'd1: frame_byte = frame_q.b1;
			3'd2: frame_byte = frame_q.b2;
			3'd3: frame_byte = frame_q.b3;
			default: frame_byte = frame_q.b4;
		endcase
	end

	assign out_valid = busy_q;
	assign frame_last = (idx_q == IDX_LAST);

endmodule

// ===== rtl/core/cdfe_checker.sv =====
// Port-level checker for the countdown display frame encoder, with its bind.
module cdfe_checker import cdfe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic       frame_last
);

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_last))
		else $error("output word changed while stalled");

	// The checksum word has its top bit clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> (frame_byte[7] == 1'b0))
		else $error("checksum word out of range");

	// After a frame ends, any following word is a frame head.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_last |=> !out_valid || (frame_byte == FRAME_HEAD))
		else $error("frame does not start with head");

	// The head is followed at once by the color and direction word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !frame_last && (frame_byte == FRAME_HEAD)
		|=> out_valid && !frame_last && frame_byte[5] && (frame_byte[7:6] == 2'd0))
		else $error("bad color and direction word after head");

endmodule

bind countdown_display_frame_encoder cdfe_checker u_cdfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frame_byte (frame_byte),
	.frame_last (frame_last)
);
